// ===== rtl/core/vector3_normalize_core_defines.svh =====
// assertion macros shared by the checker
`ifndef VECTOR3_NORMALIZE_CORE_DEFINES_SVH
`define VECTOR3_NORMALIZE_CORE_DEFINES_SVH

// implication checked outside reset
`define VNORM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vnorm assertion failed");

// implication checked in every cycle, reset included
`define VNORM_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("vnorm assertion failed");

`endif

// ===== rtl/core/vnorm_pkg.sv =====
package vnorm_pkg;

   localparam int unsigned SQRT_STAGES  = 32;
   localparam int unsigned DIV_STAGES   = 17;
   // input reg, square, sum, sqrt, divide, output reg
   localparam int unsigned CORE_LATENCY = 3 + SQRT_STAGES + DIV_STAGES + 1;
   localparam logic [31:0] Q_ONE        = 32'd65536;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic [31:0]        norm;
      logic               passed_through;
   } rsp_type;

   typedef struct packed {
      req_type          raw;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } sqrt_tag_type;

   typedef struct packed {
      req_type     raw;
      logic [2:0]  neg;
      logic [31:0] norm;
      logic        pass;
   } div_tag_type;

endpackage

// ===== rtl/core/vnorm_sqrt.sv =====
module vnorm_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  logic [63:0]            rad_in,
   input  vnorm_pkg::sqrt_tag_type tag_in,
   output logic                   valid_out,
   output logic [31:0]            root_out,
   output vnorm_pkg::sqrt_tag_type tag_out
);
   import vnorm_pkg::*;

   // index 0 is the input, index s+1 the register after step s
   logic         valid_ff [0:SQRT_STAGES];
   logic [32:0]  rem_ff   [0:SQRT_STAGES];
   logic [31:0]  root_ff  [0:SQRT_STAGES];
   logic [63:0]  rad_ff   [0:SQRT_STAGES];
   sqrt_tag_type tag_ff   [0:SQRT_STAGES];

   assign valid_ff[0] = valid_in;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign rad_ff[0]   = rad_in;
   assign tag_ff[0]   = tag_in;

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_step
      logic [34:0] cur;
      logic [34:0] trial;
      logic        take;
      logic [32:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         cur     = {rem_ff[s], rad_ff[s][63:62]};
         trial   = {1'b0, root_ff[s], 2'b01};
         take    = (cur >= trial);
         rem_in  = take ? 33'(cur - trial) : cur[32:0];
         root_in = {root_ff[s][30:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         rem_ff[s+1]  <= rem_in;
         root_ff[s+1] <= root_in;
         rad_ff[s+1]  <= {rad_ff[s][61:0], 2'b00};
         tag_ff[s+1]  <= tag_ff[s];
      end
   end

   assign valid_out = valid_ff[SQRT_STAGES];
   assign root_out  = root_ff[SQRT_STAGES];
   assign tag_out   = tag_ff[SQRT_STAGES];
endmodule

// ===== rtl/core/vnorm_div.sv =====
module vnorm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic [31:0]           len_in,
   input  logic [2:0][31:0]      mag_in,
   input  vnorm_pkg::div_tag_type tag_in,
   output logic                  valid_out,
   output logic [2:0][16:0]      quo_out,
   output vnorm_pkg::div_tag_type tag_out
);
   import vnorm_pkg::*;

   logic             valid_ff [0:DIV_STAGES];
   logic [31:0]      len_ff   [0:DIV_STAGES];
   logic [2:0][31:0] rem_ff   [0:DIV_STAGES];
   logic [2:0][16:0] quo_ff   [0:DIV_STAGES];
   div_tag_type      tag_ff   [0:DIV_STAGES];

   // dividend is mag << 16, quotient fits 17 bits, so start from mag >> 1
   assign valid_ff[0] = valid_in;
   assign len_ff[0]   = len_in;
   assign quo_ff[0]   = '0;
   assign tag_ff[0]   = tag_in;
   for (genvar l = 0; l < 3; l++) begin : g_init
      assign rem_ff[0][l] = {1'b0, mag_in[l][31:1]};
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
      logic [2:0][31:0] rem_in;
      logic [2:0][16:0] quo_in;

      always_comb begin
         logic [32:0] cur;
         logic        take;
         for (int l = 0; l < 3; l++) begin
            // only the first step brings in a dividend bit, the rest are zero
            cur  = {rem_ff[s][l], (s == 0) ? mag_in[l][0] : 1'b0};
            take = (cur >= {1'b0, len_ff[s]});
            rem_in[l] = take ? 32'(cur - {1'b0, len_ff[s]}) : cur[31:0];
            quo_in[l] = {quo_ff[s][l][15:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         len_ff[s+1] <= len_ff[s];
         rem_ff[s+1] <= rem_in;
         quo_ff[s+1] <= quo_in;
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign valid_out = valid_ff[DIV_STAGES];
   assign quo_out   = quo_ff[DIV_STAGES];
   assign tag_out   = tag_ff[DIV_STAGES];
endmodule

// ===== rtl/core/vector3_normalize_core.sv =====
// a taken transaction passes the input, square, sum, sqrt, divide and output registers
// throughput: one transaction per cycle, set by the fully pipelined sqrt and divide chains
// busy stays low, since the receiver cannot stall and nothing backs up
// reset (synchronous, active high) clears every valid bit; data registers are not reset
module vector3_normalize_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  vnorm_pkg::req_type req_item,
   output logic               rsp_valid,
   output vnorm_pkg::rsp_type rsp_item
);
   import vnorm_pkg::*;

   // input register
   logic    in_valid_ff;
   req_type in_ff;

   // squares of the component magnitudes
   logic             sq_valid_ff;
   logic [2:0][63:0] sq_ff;
   sqrt_tag_type     sq_tag_ff;

   // sum of squares
   logic         sum_valid_ff;
   logic [63:0]  sum_ff;
   sqrt_tag_type sum_tag_ff;

   // magnitude and sign of each component
   logic [2:0][31:0] mag;
   logic [2:0]       neg;
   logic [2:0][31:0] raw_word;

   // sqrt to divider hand-over
   logic         sqrt_valid;
   logic [31:0]  sqrt_root;
   sqrt_tag_type sqrt_tag;
   div_tag_type  div_tag;

   // divider results
   logic             div_valid;
   logic [2:0][16:0] div_quo;
   div_tag_type      div_tag_out;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // nothing ever holds the pipe, a transaction may enter every cycle
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_ff <= req_item;
   end

   // two's complement magnitude, the most negative value maps to 2^31 exactly
   assign raw_word[0] = in_ff.vec_x;
   assign raw_word[1] = in_ff.vec_y;
   assign raw_word[2] = in_ff.vec_z;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg[l] = raw_word[l][31];
         mag[l] = neg[l] ? 32'(~raw_word[l] + 32'd1) : raw_word[l];
      end
   end

   // one 32x32 multiplier per lane
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid_ff;
      end
      for (int l = 0; l < 3; l++) begin
         sq_ff[l] <= 64'(mag[l]) * 64'(mag[l]);
      end
      sq_tag_ff.raw <= in_ff;
      sq_tag_ff.mag <= mag;
      sq_tag_ff.neg <= neg;
   end

   // each square is at most 2^62, so the sum of three fits 64 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sq_valid_ff;
      end
      sum_ff     <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      sum_tag_ff <= sq_tag_ff;
   end

   // floor sqrt of a Q32.32 sum gives the Q16.16 norm, two radicand bits per stage
   vnorm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sum_valid_ff),
      .rad_in    (sum_ff),
      .tag_in    (sum_tag_ff),
      .valid_out (sqrt_valid),
      .root_out  (sqrt_root),
      .tag_out   (sqrt_tag)
   );

   // zero or unit norm skips scaling; the divider still runs but its result is dropped
   always_comb begin
      div_tag.raw  = sqrt_tag.raw;
      div_tag.neg  = sqrt_tag.neg;
      div_tag.norm = sqrt_root;
      div_tag.pass = (sqrt_root == '0) || (sqrt_root == Q_ONE);
   end

   // (mag << 16) / norm, one quotient bit per stage for all three lanes
   vnorm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sqrt_valid),
      .len_in    (sqrt_root),
      .mag_in    (sqrt_tag.mag),
      .tag_in    (div_tag),
      .valid_out (div_valid),
      .quo_out   (div_quo),
      .tag_out   (div_tag_out)
   );

   // restore the sign or pass raw input; the quotient never exceeds 65536 so no saturation
   always_comb begin
      logic [2:0][31:0] unit;
      logic [31:0]      qext;
      for (int l = 0; l < 3; l++) begin
         qext    = {15'b0, div_quo[l]};
         unit[l] = div_tag_out.neg[l] ? 32'(32'd0 - qext) : qext;
      end
      if (div_tag_out.pass) begin
         rsp_in.unit_x = div_tag_out.raw.vec_x;
         rsp_in.unit_y = div_tag_out.raw.vec_y;
         rsp_in.unit_z = div_tag_out.raw.vec_z;
      end else begin
         rsp_in.unit_x = unit[0];
         rsp_in.unit_y = unit[1];
         rsp_in.unit_z = unit[2];
      end
      rsp_in.norm           = div_tag_out.norm;
      rsp_in.passed_through = div_tag_out.pass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// ===== rtl/core/vnorm_checker.sv =====
`include "vector3_normalize_core_defines.svh"

module vnorm_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input vnorm_pkg::rsp_type rsp_item
);
   import vnorm_pkg::*;

   // a strobe only answers a transaction taken a fixed time earlier
   `VNORM_ASSERT_IMP(a_strobe_has_source, clock, reset, rsp_valid, $past(start, CORE_LATENCY))

   // reset empties the pipe
   `VNORM_ASSERT_ALWAYS(a_quiet_after_reset, clock, $past(reset), !rsp_valid)

   // pass-through flag only for zero or unit norm
   `VNORM_ASSERT_IMP(a_pass_norm, clock, reset, rsp_valid && rsp_item.passed_through, (rsp_item.norm == 32'd0) || (rsp_item.norm == Q_ONE))

   // scaled components stay within unit range
   `VNORM_ASSERT_IMP(a_unit_range, clock, reset, rsp_valid && !rsp_item.passed_through, (rsp_item.unit_x <= 32'sd65536) && (rsp_item.unit_x >= -32'sd65536) && (rsp_item.unit_y <= 32'sd65536) && (rsp_item.unit_y >= -32'sd65536) && (rsp_item.unit_z <= 32'sd65536) && (rsp_item.unit_z >= -32'sd65536))

   `VNORM_ASSERT_ALWAYS(a_never_busy, clock, 1'b1, !busy)
endmodule

bind vector3_normalize_core vnorm_checker u_vnorm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
